/* rtl/psd_pkg.sv */
package psd_pkg;

    localparam int COORD_W = 24;   // coordinate width, 8 fraction bits
    localparam int DIFF_W  = 25;   // difference of two coordinates
    localparam int PROD_W  = 50;   // product of two differences
    localparam int SUM_W   = 52;   // sum of three products
    localparam int MAG_W   = 50;   // magnitude of one cross product component
    localparam int HALF_W  = 25;   // half of a cross magnitude for partial products
    localparam int NUM_W   = 100;  // squared cross product length
    localparam int QUO_W   = 50;   // quotient bits, distance squared
    localparam int ROOT_W  = 25;   // distance bits
    localparam int CFG_IDX_W = 3;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } vec_t;

    // Offsets of the query point from the start and from the end point.
    typedef struct packed {
        vec_t w;
        vec_t e;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
    } seg_t;

endpackage

/* rtl/psd_front.sv */
module psd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  psd_pkg::seg_t                       seg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [psd_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [psd_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [psd_pkg::COORD_W-1:0]  s_point_z,
    input  logic                                q_full,
    output logic                                q_push,
    output psd_pkg::item_t                      q_item
);

    logic           valid_reg;
    psd_pkg::item_t item_reg;
    psd_pkg::item_t item_next;

    assign q_push  = valid_reg && !q_full;
    assign s_ready = !valid_reg || !q_full;
    assign q_item  = item_reg;

    always_comb begin
        item_next.w.x = psd_pkg::DIFF_W'(s_point_x) - psd_pkg::DIFF_W'(seg.sx);
        item_next.w.y = psd_pkg::DIFF_W'(s_point_y) - psd_pkg::DIFF_W'(seg.sy);
        item_next.w.z = psd_pkg::DIFF_W'(s_point_z) - psd_pkg::DIFF_W'(seg.sz);
        item_next.e.x = psd_pkg::DIFF_W'(s_point_x) - psd_pkg::DIFF_W'(seg.ex);
        item_next.e.y = psd_pkg::DIFF_W'(s_point_y) - psd_pkg::DIFF_W'(seg.ey);
        item_next.e.z = psd_pkg::DIFF_W'(s_point_z) - psd_pkg::DIFF_W'(seg.ez);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/psd_fifo.sv */
module psd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  psd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output psd_pkg::item_t head
);

    psd_pkg::item_t              mem [0:psd_pkg::DEPTH-1];
    logic [psd_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [psd_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [psd_pkg::CNT_W-1:0]   count_reg;

    assign full  = (count_reg == psd_pkg::CNT_W'(psd_pkg::DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("item popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= psd_pkg::CNT_W'(psd_pkg::DEPTH))
        else $error("queue count beyond its depth");

endmodule

/* rtl/psd_back.sv */
module psd_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  psd_pkg::seg_t                    seg,
    input  logic                             q_empty,
    input  psd_pkg::item_t                   q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    output logic [psd_pkg::NUM_W-1:0]        out_num,
    output logic [psd_pkg::SUM_W-1:0]        out_len,
    output psd_pkg::region_t                 out_region
);

    typedef struct packed {
        logic signed [psd_pkg::PROD_W-1:0] t0x, t0y, t0z;
        logic signed [psd_pkg::PROD_W-1:0] t1x, t1y, t1z;
        logic signed [psd_pkg::PROD_W-1:0] wydz, wzdy, wzdx, wxdz, wxdy, wydx;
        logic signed [psd_pkg::PROD_W-1:0] wwx, wwy, wwz;
        logic signed [psd_pkg::PROD_W-1:0] eex, eey, eez;
        logic signed [psd_pkg::PROD_W-1:0] ddx, ddy, ddz;
    } prod_t;

    typedef struct packed {
        psd_pkg::region_t             region;
        logic                         deg;
        logic [psd_pkg::SUM_W-1:0]    simp;
        logic [psd_pkg::SUM_W-1:0]    len;
        logic [psd_pkg::MAG_W-1:0]    cx, cy, cz;
    } sums_t;

    typedef struct packed {
        psd_pkg::region_t             region;
        logic                         deg;
        logic [psd_pkg::SUM_W-1:0]    simp;
        logic [psd_pkg::SUM_W-1:0]    len;
        logic [psd_pkg::PROD_W-1:0]   xhh, xhl, xll;
        logic [psd_pkg::PROD_W-1:0]   yhh, yhl, yll;
        logic [psd_pkg::PROD_W-1:0]   zhh, zhl, zll;
    } part_t;

    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    psd_pkg::item_t s1_item_reg;
    psd_pkg::vec_t  s1_d_reg;
    psd_pkg::vec_t  d_next;
    prod_t          s2_reg, s2_next;
    sums_t          s3_reg, s3_next;
    part_t          s4_reg, s4_next;
    logic [psd_pkg::NUM_W-1:0] num_reg, num_next;
    logic [psd_pkg::SUM_W-1:0] len_reg, len_next;
    psd_pkg::region_t          region_reg;

    assign q_pop      = en && !q_empty;
    assign out_valid  = s5_valid_reg;
    assign out_num    = num_reg;
    assign out_len    = len_reg;
    assign out_region = region_reg;

    always_comb begin
        d_next.x = psd_pkg::DIFF_W'(seg.ex) - psd_pkg::DIFF_W'(seg.sx);
        d_next.y = psd_pkg::DIFF_W'(seg.ey) - psd_pkg::DIFF_W'(seg.sy);
        d_next.z = psd_pkg::DIFF_W'(seg.ez) - psd_pkg::DIFF_W'(seg.sz);
    end

    always_comb begin
        s2_next.t0x  = s1_item_reg.w.x * s1_d_reg.x;
        s2_next.t0y  = s1_item_reg.w.y * s1_d_reg.y;
        s2_next.t0z  = s1_item_reg.w.z * s1_d_reg.z;
        s2_next.t1x  = s1_item_reg.e.x * s1_d_reg.x;
        s2_next.t1y  = s1_item_reg.e.y * s1_d_reg.y;
        s2_next.t1z  = s1_item_reg.e.z * s1_d_reg.z;
        s2_next.wydz = s1_item_reg.w.y * s1_d_reg.z;
        s2_next.wzdy = s1_item_reg.w.z * s1_d_reg.y;
        s2_next.wzdx = s1_item_reg.w.z * s1_d_reg.x;
        s2_next.wxdz = s1_item_reg.w.x * s1_d_reg.z;
        s2_next.wxdy = s1_item_reg.w.x * s1_d_reg.y;
        s2_next.wydx = s1_item_reg.w.y * s1_d_reg.x;
        s2_next.wwx  = s1_item_reg.w.x * s1_item_reg.w.x;
        s2_next.wwy  = s1_item_reg.w.y * s1_item_reg.w.y;
        s2_next.wwz  = s1_item_reg.w.z * s1_item_reg.w.z;
        s2_next.eex  = s1_item_reg.e.x * s1_item_reg.e.x;
        s2_next.eey  = s1_item_reg.e.y * s1_item_reg.e.y;
        s2_next.eez  = s1_item_reg.e.z * s1_item_reg.e.z;
        s2_next.ddx  = s1_d_reg.x * s1_d_reg.x;
        s2_next.ddy  = s1_d_reg.y * s1_d_reg.y;
        s2_next.ddz  = s1_d_reg.z * s1_d_reg.z;
    end

    always_comb begin
        logic signed [psd_pkg::SUM_W-1:0] t0, t1, cxs, cys, czs, cxn, cyn, czn;
        logic [psd_pkg::SUM_W-1:0]        sqw, sqe;
        t0  = psd_pkg::SUM_W'(s2_reg.t0x) + psd_pkg::SUM_W'(s2_reg.t0y)
            + psd_pkg::SUM_W'(s2_reg.t0z);
        t1  = psd_pkg::SUM_W'(s2_reg.t1x) + psd_pkg::SUM_W'(s2_reg.t1y)
            + psd_pkg::SUM_W'(s2_reg.t1z);
        cxs = psd_pkg::SUM_W'(s2_reg.wydz) - psd_pkg::SUM_W'(s2_reg.wzdy);
        cys = psd_pkg::SUM_W'(s2_reg.wzdx) - psd_pkg::SUM_W'(s2_reg.wxdz);
        czs = psd_pkg::SUM_W'(s2_reg.wxdy) - psd_pkg::SUM_W'(s2_reg.wydx);
        cxn = -cxs;
        cyn = -cys;
        czn = -czs;
        sqw = psd_pkg::SUM_W'(s2_reg.wwx) + psd_pkg::SUM_W'(s2_reg.wwy)
            + psd_pkg::SUM_W'(s2_reg.wwz);
        sqe = psd_pkg::SUM_W'(s2_reg.eex) + psd_pkg::SUM_W'(s2_reg.eey)
            + psd_pkg::SUM_W'(s2_reg.eez);
        s3_next.len = psd_pkg::SUM_W'(s2_reg.ddx) + psd_pkg::SUM_W'(s2_reg.ddy)
                    + psd_pkg::SUM_W'(s2_reg.ddz);
        s3_next.deg = (s3_next.len == '0);
        s3_next.cx  = cxs[psd_pkg::SUM_W-1] ? cxn[psd_pkg::MAG_W-1:0] : cxs[psd_pkg::MAG_W-1:0];
        s3_next.cy  = cys[psd_pkg::SUM_W-1] ? cyn[psd_pkg::MAG_W-1:0] : cys[psd_pkg::MAG_W-1:0];
        s3_next.cz  = czs[psd_pkg::SUM_W-1] ? czn[psd_pkg::MAG_W-1:0] : czs[psd_pkg::MAG_W-1:0];
        // The projection parameter decides the nearest feature of the segment.
        priority if (t0[psd_pkg::SUM_W-1]) begin
            s3_next.region = psd_pkg::REGION_START;
            s3_next.simp   = sqw;
        end else if (!t1[psd_pkg::SUM_W-1] && (t1 != '0)) begin
            s3_next.region = psd_pkg::REGION_END;
            s3_next.simp   = sqe;
        end else begin
            s3_next.region = psd_pkg::REGION_INTERIOR;
            s3_next.simp   = sqw;
        end
    end

    always_comb begin
        s4_next.region = s3_reg.region;
        s4_next.deg    = s3_reg.deg;
        s4_next.simp   = s3_reg.simp;
        s4_next.len    = s3_reg.len;
        s4_next.xhh = s3_reg.cx[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cx[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        s4_next.xhl = s3_reg.cx[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cx[psd_pkg::HALF_W-1:0];
        s4_next.xll = s3_reg.cx[psd_pkg::HALF_W-1:0] * s3_reg.cx[psd_pkg::HALF_W-1:0];
        s4_next.yhh = s3_reg.cy[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cy[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        s4_next.yhl = s3_reg.cy[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cy[psd_pkg::HALF_W-1:0];
        s4_next.yll = s3_reg.cy[psd_pkg::HALF_W-1:0] * s3_reg.cy[psd_pkg::HALF_W-1:0];
        s4_next.zhh = s3_reg.cz[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cz[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        s4_next.zhl = s3_reg.cz[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * s3_reg.cz[psd_pkg::HALF_W-1:0];
        s4_next.zll = s3_reg.cz[psd_pkg::HALF_W-1:0] * s3_reg.cz[psd_pkg::HALF_W-1:0];
    end

    always_comb begin
        logic [psd_pkg::NUM_W-1:0] hh, hl, ll;
        hh = psd_pkg::NUM_W'(s4_reg.xhh) + psd_pkg::NUM_W'(s4_reg.yhh)
           + psd_pkg::NUM_W'(s4_reg.zhh);
        hl = psd_pkg::NUM_W'(s4_reg.xhl) + psd_pkg::NUM_W'(s4_reg.yhl)
           + psd_pkg::NUM_W'(s4_reg.zhl);
        ll = psd_pkg::NUM_W'(s4_reg.xll) + psd_pkg::NUM_W'(s4_reg.yll)
           + psd_pkg::NUM_W'(s4_reg.zll);
        // Endpoint cases and a zero-length segment take a plain square root.
        if ((s4_reg.region != psd_pkg::REGION_INTERIOR) || s4_reg.deg) begin
            num_next = psd_pkg::NUM_W'(s4_reg.simp);
            len_next = psd_pkg::SUM_W'(1);
        end else begin
            num_next = (hh << (2 * psd_pkg::HALF_W)) + (hl << (psd_pkg::HALF_W + 1)) + ll;
            len_next = s4_reg.len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg <= q_head;
            s1_d_reg    <= d_next;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s4_reg      <= s4_next;
            num_reg     <= num_next;
            len_reg     <= len_next;
            region_reg  <= s4_reg.region;
        end
    end

endmodule

/* rtl/psd_root.sv */
module psd_root (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [psd_pkg::NUM_W-1:0]        in_num,
    input  logic [psd_pkg::SUM_W-1:0]        in_len,
    input  psd_pkg::region_t                 in_region,
    output logic                             out_valid,
    output logic [psd_pkg::ROOT_W-1:0]       out_root,
    output psd_pkg::region_t                 out_region
);

    logic                        dv_reg  [0:psd_pkg::QUO_W-1];
    logic [psd_pkg::NUM_W-1:0]   rem_reg [0:psd_pkg::QUO_W-1];
    logic [psd_pkg::SUM_W-1:0]   len_reg [0:psd_pkg::QUO_W-1];
    logic [psd_pkg::QUO_W-1:0]   quo_reg [0:psd_pkg::QUO_W-1];
    psd_pkg::region_t            dr_reg  [0:psd_pkg::QUO_W-1];

    logic                        sv_reg  [0:psd_pkg::ROOT_W-1];
    logic [psd_pkg::QUO_W-1:0]   val_reg [0:psd_pkg::ROOT_W-1];
    logic [psd_pkg::ROOT_W-1:0]  rt_reg  [0:psd_pkg::ROOT_W-1];
    psd_pkg::region_t            sr_reg  [0:psd_pkg::ROOT_W-1];

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < psd_pkg::QUO_W; k++) begin : g_div
        localparam int B = psd_pkg::QUO_W - 1 - k;
        logic                       vin;
        logic [psd_pkg::NUM_W-1:0]  rin, shifted, rem_next;
        logic [psd_pkg::SUM_W-1:0]  lin;
        logic [psd_pkg::QUO_W-1:0]  qin, quo_next;
        psd_pkg::region_t           gin;

        if (k == 0) begin : g_first
            assign vin = in_valid;
            assign rin = in_num;
            assign lin = in_len;
            assign qin = '0;
            assign gin = in_region;
        end else begin : g_rest
            assign vin = dv_reg[k-1];
            assign rin = rem_reg[k-1];
            assign lin = len_reg[k-1];
            assign qin = quo_reg[k-1];
            assign gin = dr_reg[k-1];
        end

        always_comb begin
            shifted = psd_pkg::NUM_W'(lin) << B;
            if (rin >= shifted) begin
                rem_next = rin - shifted;
                quo_next = qin | (psd_pkg::QUO_W'(1) << B);
            end else begin
                rem_next = rin;
                quo_next = qin;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                len_reg[k] <= lin;
                quo_reg[k] <= quo_next;
                dr_reg[k]  <= gin;
            end
        end
    end

    // Square root of the quotient, one result bit per stage.
    for (genvar k = 0; k < psd_pkg::ROOT_W; k++) begin : g_sqrt
        localparam int B = psd_pkg::ROOT_W - 1 - k;
        logic                        vin;
        logic [psd_pkg::QUO_W-1:0]   xin;
        logic [psd_pkg::ROOT_W-1:0]  qin, cand, rt_next;
        logic [psd_pkg::PROD_W-1:0]  sq;
        psd_pkg::region_t            gin;

        if (k == 0) begin : g_first
            assign vin = dv_reg[psd_pkg::QUO_W-1];
            assign xin = quo_reg[psd_pkg::QUO_W-1];
            assign qin = '0;
            assign gin = dr_reg[psd_pkg::QUO_W-1];
        end else begin : g_rest
            assign vin = sv_reg[k-1];
            assign xin = val_reg[k-1];
            assign qin = rt_reg[k-1];
            assign gin = sr_reg[k-1];
        end

        always_comb begin
            cand    = qin | (psd_pkg::ROOT_W'(1) << B);
            sq      = cand * cand;
            rt_next = (psd_pkg::QUO_W'(sq) <= xin) ? cand : qin;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k] <= 1'b0;
            end else if (en) begin
                sv_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                val_reg[k] <= xin;
                rt_reg[k]  <= rt_next;
                sr_reg[k]  <= gin;
            end
        end
    end

    assign out_valid  = sv_reg[psd_pkg::ROOT_W-1];
    assign out_root   = rt_reg[psd_pkg::ROOT_W-1];
    assign out_region = sr_reg[psd_pkg::ROOT_W-1];

endmodule

/* rtl/point_segment_distance_3d_top.sv */
// Throughput: one item per cycle while the output is not stalled; the back-end, divider
// and square root stages advance together whenever the output register is empty or
// being taken, and a four-item queue decouples the input register from the pipe.
// The 50-stage divider and 25-stage square root set the depth of the pipeline.
// Reset (aresetn low at a clock edge) clears the segment registers to zero and empties
// the queue and all pipeline stages.
module point_segment_distance_3d_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [psd_pkg::COORD_W-1:0]            cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [psd_pkg::COORD_W-1:0]     s_point_x,
    input  logic signed [psd_pkg::COORD_W-1:0]     s_point_y,
    input  logic signed [psd_pkg::COORD_W-1:0]     s_point_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [psd_pkg::ROOT_W-1:0]             m_distance,
    output logic [1:0]                             m_region
);

    psd_pkg::seg_t             seg_reg;
    logic                      en;
    logic                      q_full, q_push, q_empty, q_pop;
    psd_pkg::item_t            q_item, q_head;
    logic                      b_valid;
    logic [psd_pkg::NUM_W-1:0] b_num;
    logic [psd_pkg::SUM_W-1:0] b_len;
    psd_pkg::region_t          b_region, out_region;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign m_region  = out_region;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                psd_pkg::CFG_START_X: seg_reg.sx <= cfg_data;
                psd_pkg::CFG_START_Y: seg_reg.sy <= cfg_data;
                psd_pkg::CFG_START_Z: seg_reg.sz <= cfg_data;
                psd_pkg::CFG_END_X:   seg_reg.ex <= cfg_data;
                psd_pkg::CFG_END_Y:   seg_reg.ey <= cfg_data;
                psd_pkg::CFG_END_Z:   seg_reg.ez <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    psd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seg       (seg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .s_point_z (s_point_z),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    psd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    psd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .seg        (seg_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (b_valid),
        .out_num    (b_num),
        .out_len    (b_len),
        .out_region (b_region)
    );

    psd_root u_root (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (b_valid),
        .in_num     (b_num),
        .in_len     (b_len),
        .in_region  (b_region),
        .out_valid  (m_valid),
        .out_root   (m_distance),
        .out_region (out_region)
    );

endmodule

/* tb/sv/point_segment_distance_3d_checker.sv */
`timescale 1ns / 100ps

module point_segment_distance_3d_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psd_pkg::COORD_W-1:0]       cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [psd_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [psd_pkg::COORD_W-1:0] s_point_y,
    input  logic signed [psd_pkg::COORD_W-1:0] s_point_z,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [psd_pkg::ROOT_W-1:0]        m_distance,
    input  logic [1:0]                        m_region,
    output int                                errors,
    output int                                outstanding,
    output int                                checked,
    output int                                region_hits [3]
);

    typedef struct {
        logic [psd_pkg::ROOT_W-1:0] distance;
        psd_pkg::region_t           region;
    } distance_result_t;

    distance_result_t expected_distances [$];
    logic signed [psd_pkg::COORD_W-1:0] seg_reg [6];

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // floor(sqrt(num / den)), built bit by bit from the top.
    function automatic logic [psd_pkg::ROOT_W-1:0] root_of_ratio(input logic [127:0] num,
                                                                 input logic [63:0] den);
        logic [25:0]  q;
        logic [127:0] c;
        q = '0;
        for (int b = 25; b >= 0; b--) begin
            c = 128'(q | (26'd1 << b));
            if (c * c * 128'(den) <= num)
                q = q | (26'd1 << b);
        end
        return q[psd_pkg::ROOT_W-1:0];
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] norm2(input longint a, input longint b, input longint c);
        return abs64(a) * abs64(a) + abs64(b) * abs64(b) + abs64(c) * abs64(c);
    endfunction

    function automatic distance_result_t segment_distance(input longint px, input longint py,
                                                           input longint pz);
        distance_result_t r;
        longint dx, dy, dz, wx, wy, wz, ex, ey, ez, t0, t1, cx, cy, cz;
        logic [63:0]  len2;
        logic [127:0] n;
        dx = longint'(seg_reg[3]) - seg_reg[0];
        dy = longint'(seg_reg[4]) - seg_reg[1];
        dz = longint'(seg_reg[5]) - seg_reg[2];
        wx = px - seg_reg[0];
        wy = py - seg_reg[1];
        wz = pz - seg_reg[2];
        ex = px - seg_reg[3];
        ey = py - seg_reg[4];
        ez = pz - seg_reg[5];
        t0 = wx * dx + wy * dy + wz * dz;
        t1 = ex * dx + ey * dy + ez * dz;
        if (t0 < 0) begin
            r.region = psd_pkg::REGION_START;
            r.distance = root_of_ratio(128'(norm2(wx, wy, wz)), 64'd1);
        end else if (t1 > 0) begin
            r.region = psd_pkg::REGION_END;
            r.distance = root_of_ratio(128'(norm2(ex, ey, ez)), 64'd1);
        end else begin
            r.region = psd_pkg::REGION_INTERIOR;
            len2 = norm2(dx, dy, dz);
            if (len2 == 0) begin
                r.distance = root_of_ratio(128'(norm2(wx, wy, wz)), 64'd1);
            end else begin
                cx = wy * dz - wz * dy;
                cy = wz * dx - wx * dz;
                cz = wx * dy - wy * dx;
                n = 128'(abs64(cx)) * abs64(cx) + 128'(abs64(cy)) * abs64(cy)
                    + 128'(abs64(cz)) * abs64(cz);
                r.distance = root_of_ratio(n, len2);
            end
        end
        return r;
    endfunction

    initial begin
        errors = 0;
        checked = 0;
        outstanding = 0;
        for (int i = 0; i < 3; i++) region_hits[i] = 0;
        for (int i = 0; i < 6; i++) seg_reg[i] = '0;
    end

    always @(posedge aclk) begin
        distance_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < psd_pkg::CFG_IDX_W'(6))
                seg_reg[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                expected_distances.insert(expected_distances.size(),
                    segment_distance(s_point_x, s_point_y, s_point_z));
            if (m_valid && m_ready) begin
                if (expected_distances.size() == 0) begin
                    report($sformatf("unexpected item distance=%0d region=%0d",
                                     m_distance, m_region));
                end else begin
                    want = expected_distances.pop_front();
                    checked++;
                    region_hits[want.region]++;
                    if (m_distance !== want.distance)
                        report($sformatf("distance %0d, expected %0d", m_distance,
                                         want.distance));
                    if (m_region !== want.region)
                        report($sformatf("region %0d, expected %0d", m_region, want.region));
                end
            end
        end
        outstanding = expected_distances.size();
    end

endmodule

/* tb/sv/point_segment_distance_3d_top_tb.sv */
`timescale 1ns / 100ps

module point_segment_distance_3d_top_tb;

    localparam int DRAIN_CYCLES = 120;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [psd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [psd_pkg::COORD_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [psd_pkg::COORD_W-1:0] s_point_x = '0;
    logic signed [psd_pkg::COORD_W-1:0] s_point_y = '0;
    logic signed [psd_pkg::COORD_W-1:0] s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [psd_pkg::ROOT_W-1:0] m_distance;
    logic [1:0] m_region;

    int errors, outstanding, checked;
    int region_hits [3];
    int seg_now [6];
    int sent = 0;
    int rx_gap_left = 0;
    bit rx_quiet = 0;
    bit rx_hold = 0;
    event hold_go;

    point_segment_distance_3d_top dut (.*);

    point_segment_distance_3d_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            m_ready <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
            m_ready <= 1'b0;
            rx_gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(hold_go);
            rx_hold = 1;
            repeat (400) @(posedge aclk);
            rx_hold = 0;
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", outstanding);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return int'(v);
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Called and returns at a rising edge; valid stays high afterwards.
    task automatic send_point(input int x, input int y, input int z, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= psd_pkg::COORD_W'(x);
        s_point_y <= psd_pkg::COORD_W'(y);
        s_point_z <= psd_pkg::COORD_W'(z);
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic cfg_write(input logic [psd_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= psd_pkg::COORD_W'(val);
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        if (idx < 6) seg_now[idx] = val;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_segment(input int sx, input int sy, input int sz,
                               input int ex, input int ey, input int ez);
        drain();
        cfg_write(psd_pkg::CFG_START_X, sx);
        cfg_write(psd_pkg::CFG_START_Y, sy);
        cfg_write(psd_pkg::CFG_START_Z, sz);
        cfg_write(psd_pkg::CFG_END_X, ex);
        cfg_write(psd_pkg::CFG_END_Y, ey);
        cfg_write(psd_pkg::CFG_END_Z, ez);
        // Indexes past the last register must be ignored.
        cfg_write(psd_pkg::CFG_IDX_W'($urandom_range(6, 7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_points(input int count, input bit quiet);
        int p [3];
        int k, mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            k = $urandom_range(0, 20) - 2;
            for (int a = 0; a < 3; a++) begin
                if (mode < 3)
                    p[a] = $signed(24'($urandom));
                else if (mode == 3)
                    p[a] = edge_coord();
                else
                    p[a] = clamp_coord(longint'(seg_now[a])
                        + (longint'(seg_now[a + 3]) - seg_now[a]) * k / 16
                        + $signed(12'($urandom)));
            end
            send_point(p[0], p[1], p[2], pick_gap(quiet));
        end
    endtask

    task automatic random_segment(input int span);
        int v [6];
        for (int i = 0; i < 6; i++)
            v[i] = (span == 0) ? $signed(24'($urandom)) : $urandom_range(0, 2 * span) - span;
        set_segment(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset leaves a degenerate segment at the origin.
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        send_point(COORD_MIN, COORD_MAX, 0, 1);
        send_point(0, 0, 0, 0);

        set_segment(0, 0, 0, 2560, 0, 0);
        send_point(-256, 100, 0, 0);
        send_point(5000, 0, -100, 0);
        send_point(1280, 512, 512, 2);
        send_point(0, 700, 0, 0);
        send_point(2560, 0, 700, 0);
        send_point(0, 0, 0, 0);
        send_point(2560, 0, 0, 0);
        send_point(-1, 0, 0, 0);
        send_point(2561, 0, 0, 0);

        set_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_point(0, 0, 0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MIN, 0);
        random_points(150, 0);

        set_segment(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, COORD_MAX);
        random_points(150, 0);

        random_segment(0);
        random_points(200, 1);

        // Fill the pipe against a long output hold-off.
        random_segment(4096);
        ->hold_go;
        random_points(150, 1);

        drain();
        random_points(150, 0);

        // Degenerate segment away from the origin.
        set_segment(-300000, 77, 5000000, -300000, 77, 5000000);
        random_points(150, 0);

        for (int ph = 0; ph < 4; ph++) begin
            random_segment(ph[0] ? 2000 : 0);
            random_points(250, ph == 2);
        end

        set_segment(0, 0, 0, 0, 0, 0);
        random_points(60, 0);

        drain();
        $display("%0d points sent, %0d results checked over several segment settings",
                 sent, checked);
        $display("regions seen: start %0d, end %0d, interior %0d",
                 region_hits[0], region_hits[1], region_hits[2]);
        if (errors == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_fifo.sv
rtl/psd_back.sv
rtl/psd_root.sv
rtl/point_segment_distance_3d_top.sv
tb/sv/point_segment_distance_3d_checker.sv
tb/sv/point_segment_distance_3d_top_tb.sv
